// ===== sv/fwf_pkg.sv =====
// shared constants and codes for the forward filter
package fwf_pkg;

  localparam int MAX_STATES_DEF  = 8;
  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int PROB_BITS       = 16;

  localparam int MODE_BITS  = 3;
  localparam int ROW_BITS   = 3;
  localparam int COL_BITS   = 4;
  localparam int SYM_BITS   = 4;
  localparam int CFG_BITS   = 4;
  localparam int CFG_RESET  = 8;

  typedef logic [MODE_BITS-1:0] mode_t;

  localparam mode_t MODE_WR_TRANS = 3'd0;
  localparam mode_t MODE_WR_EMIS  = 3'd1;
  localparam mode_t MODE_WR_START = 3'd2;
  localparam mode_t MODE_RESTART  = 3'd3;
  localparam mode_t MODE_OBSERVE  = 3'd4;

endpackage

// ===== sv/hmm_forward_filter.sv =====
// top level of the normalized forward filter: tables, sequencer, shared multiplier
//
// usage
//   input channel (in_valid / in_stall): one transaction carries mode, row_state,
//   column_index, prob_value and obs_symbol. table writes and restart give no result.
//   an observe transaction gives one result per used state (state_index,
//   posterior, zero_evidence), the final one with last set.
//   config: cfg_we with cfg_data writes states_in_use (0 acts as 1, above
//   MAX_STATES acts as MAX_STATES); write it only while the block is idle.
// timing
//   one shared multiplier does every product. an observe first runs the
//   multiply-accumulate, then (unless the evidence is zero) the bit-serial
//   divider once per state, then hands out the results; values are Q0.16.
//   in_stall stays high for the whole observe, including the result hand-off.
// reset
//   rst clears the belief to zero, sets states_in_use to 8 and returns to idle.
//   the tables are not cleared and must be written before they are used.
// output stall
//   results leave from registers; while out_stall is high the current result
//   holds and the sequencer waits.
module hmm_forward_filter #(
  parameter int MAX_STATES  = fwf_pkg::MAX_STATES_DEF,
  parameter int MAX_SYMBOLS = fwf_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fwf_pkg::CFG_BITS-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fwf_pkg::MODE_BITS-1:0]  mode,
  input  logic [fwf_pkg::ROW_BITS-1:0]   row_state,
  input  logic [fwf_pkg::COL_BITS-1:0]   column_index,
  input  logic [fwf_pkg::PROB_BITS-1:0]  prob_value,
  input  logic [fwf_pkg::SYM_BITS-1:0]   obs_symbol,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fwf_pkg::ROW_BITS-1:0]   state_index,
  output logic [fwf_pkg::PROB_BITS-1:0]  posterior,
  output logic                           last,
  output logic                           zero_evidence
);
  import fwf_pkg::*;

  localparam int SW   = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int NW   = $clog2(MAX_STATES + 1);
  localparam int TAW  = $clog2(MAX_STATES * MAX_STATES);
  localparam int EAW  = $clog2(MAX_STATES * MAX_SYMBOLS);
  localparam int DENW = PROB_BITS + $clog2(MAX_STATES + 1);
  localparam int TDEPTH = MAX_STATES * MAX_STATES;
  localparam int EDEPTH = MAX_STATES * MAX_SYMBOLS;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_TREAD  = 8'b0000_0010,
    S_TMAC   = 8'b0000_0100,
    S_EREAD  = 8'b0000_1000,
    S_EMUL   = 8'b0001_0000,
    S_DSTART = 8'b0010_0000,
    S_DWAIT  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [CFG_BITS-1:0]  states_in_use;
  logic [NW-1:0]        n_used;
  logic [SW-1:0]        last_idx;

  // tables
  logic [PROB_BITS-1:0] trans_mem [TDEPTH];
  logic [PROB_BITS-1:0] emis_mem  [EDEPTH];
  logic [PROB_BITS-1:0] start_probs [MAX_STATES];
  logic [PROB_BITS-1:0] belief      [MAX_STATES];
  logic [PROB_BITS-1:0] wbuf        [MAX_STATES];

  logic [PROB_BITS-1:0] trans_q;
  logic [PROB_BITS-1:0] emis_q;
  logic                 sym_ok;

  // sequencer registers
  logic [SW-1:0]        x;
  logic [SW-1:0]        i;
  logic [PROB_BITS-1:0] pred;
  logic [DENW-1:0]      den;
  logic [SYM_BITS-1:0]  sym;
  logic                 zero_flag;

  // shared multiplier
  logic [PROB_BITS-1:0]   mul_a;
  logic [PROB_BITS-1:0]   mul_b;
  logic [2*PROB_BITS-1:0] mul_full;
  logic [PROB_BITS-1:0]   mul_res;
  logic [PROB_BITS:0]     pred_sum;
  logic [DENW-1:0]        den_sum;

  logic                 accept;
  logic                 div_start;
  logic                 div_done;
  logic [PROB_BITS-1:0] div_quo;

  logic                 wr_trans_ok;
  logic                 wr_emis_ok;
  logic                 wr_start_ok;
  logic [TAW-1:0]       trans_wr_addr;
  logic [EAW-1:0]       emis_wr_addr;
  logic [TAW-1:0]       trans_rd_addr;
  logic [EAW-1:0]       emis_rd_addr;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // clamp of the used-state count
  always_comb begin
    if (states_in_use == '0) begin
      n_used = NW'(1);
    end else if (int'(states_in_use) > MAX_STATES) begin
      n_used = NW'(MAX_STATES);
    end else begin
      n_used = NW'(states_in_use);
    end
    last_idx = SW'(n_used - NW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      states_in_use <= CFG_BITS'(CFG_RESET);
    end else if (cfg_we) begin
      states_in_use <= cfg_data;
    end
  end

  // write decode, out-of-range indices drop the write
  always_comb begin
    wr_trans_ok   = accept && (mode == MODE_WR_TRANS) && (int'(row_state) < MAX_STATES)
                    && (int'(column_index) < MAX_STATES);
    wr_emis_ok    = accept && (mode == MODE_WR_EMIS) && (int'(row_state) < MAX_STATES)
                    && (int'(column_index) < MAX_SYMBOLS);
    wr_start_ok   = accept && (mode == MODE_WR_START) && (int'(row_state) < MAX_STATES);
    trans_wr_addr = TAW'(int'(row_state) * MAX_STATES + int'(column_index));
    emis_wr_addr  = EAW'(int'(row_state) * MAX_SYMBOLS + int'(column_index));
    trans_rd_addr = TAW'(int'(x) * MAX_STATES + int'(i));
    emis_rd_addr  = EAW'(int'(x) * MAX_SYMBOLS + int'(sym));
  end

  always_ff @(posedge clk) begin
    if (wr_trans_ok) begin
      trans_mem[trans_wr_addr] <= prob_value;
    end
    trans_q <= trans_mem[trans_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_emis_ok) begin
      emis_mem[emis_wr_addr] <= prob_value;
    end
    emis_q <= emis_mem[emis_rd_addr];
    sym_ok <= (int'(sym) < MAX_SYMBOLS);
  end

  always_ff @(posedge clk) begin
    if (wr_start_ok) begin
      start_probs[SW'(row_state)] <= prob_value;
    end
  end

  // one multiplier: transition x belief, then emission x prediction
  always_comb begin
    if (state == S_EMUL) begin
      mul_a = sym_ok ? emis_q : '0;
      mul_b = pred;
    end else begin
      mul_a = trans_q;
      mul_b = belief[i];
    end
    mul_full = mul_a * mul_b;
    mul_res  = mul_full[2*PROB_BITS-1:PROB_BITS];
    pred_sum = {1'b0, pred} + {1'b0, mul_res};
    den_sum  = den + DENW'(mul_res);
  end

  assign div_start = (state == S_DSTART);

  fwf_div #(
    .DEN_BITS(DENW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (wbuf[x]),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && mode == MODE_OBSERVE) state_next = S_TREAD;
      end
      S_TREAD:  state_next = S_TMAC;
      S_TMAC:   state_next = (i == last_idx) ? S_EREAD : S_TREAD;
      S_EREAD:  state_next = S_EMUL;
      S_EMUL: begin
        if (x != last_idx) begin
          state_next = S_TREAD;
        end else if (den_sum == '0) begin
          state_next = S_OUT;
        end else begin
          state_next = S_DSTART;
        end
      end
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT: begin
        if (div_done) state_next = (x == last_idx) ? S_OUT : S_DSTART;
      end
      S_OUT: begin
        if (!out_stall && x == last_idx) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // loop counters and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      x         <= '0;
      i         <= '0;
      zero_flag <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          x    <= '0;
          i    <= '0;
          pred <= '0;
          den  <= '0;
          sym  <= obs_symbol;
        end
        S_TMAC: begin
          pred <= pred_sum[PROB_BITS] ? '1 : pred_sum[PROB_BITS-1:0];
          i    <= (i == last_idx) ? '0 : i + SW'(1);
        end
        S_EMUL: begin
          wbuf[x]   <= mul_res;
          den       <= den_sum;
          pred      <= '0;
          x         <= (x == last_idx) ? '0 : x + SW'(1);
          zero_flag <= (den_sum == '0);
        end
        S_DWAIT: begin
          if (div_done) x <= (x == last_idx) ? '0 : x + SW'(1);
        end
        S_OUT: begin
          if (!out_stall) x <= (x == last_idx) ? '0 : x + SW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // belief: restart copies the start table, each division writes one state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_STATES; k++) belief[k] <= '0;
    end else if (accept && mode == MODE_RESTART) begin
      for (int k = 0; k < MAX_STATES; k++) belief[k] <= start_probs[k];
    end else if (state == S_DWAIT && div_done) begin
      belief[x] <= div_quo;
    end
  end

  // results come straight from registers held while stalled
  assign out_valid     = (state == S_OUT);
  assign state_index   = ROW_BITS'(x);
  assign posterior     = belief[x];
  assign last          = (x == last_idx);
  assign zero_evidence = zero_flag;

endmodule

// ===== sv/fwf_div.sv =====
// restoring divider for the normalization, one quotient bit per cycle
module fwf_div #(
  parameter int DEN_BITS = 19
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [fwf_pkg::PROB_BITS-1:0]  num,
  input  logic [DEN_BITS-1:0]            den,
  output logic                           done,
  output logic [fwf_pkg::PROB_BITS-1:0]  quo
);
  import fwf_pkg::*;

  localparam int CW = $clog2(PROB_BITS + 1);

  logic                  active;
  logic                  sat;
  logic [CW-1:0]         cnt;
  logic [DEN_BITS-1:0]   rem;
  logic [DEN_BITS-1:0]   dvs;
  logic [DEN_BITS:0]     shifted;
  logic                  fits;

  // numerator is at most the divisor, so only the fraction bits are needed
  assign shifted = {rem, 1'b0};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && (sat || cnt == CW'(1))) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DEN_BITS'(num);
      dvs <= den;
      sat <= (DEN_BITS'(num) == den);
      cnt <= CW'(PROB_BITS);
      quo <= '0;
    end else if (active) begin
      if (sat) begin
        quo <= '1;
      end else begin
        cnt <= cnt - CW'(1);
        if (fits) begin
          rem <= DEN_BITS'(shifted - {1'b0, dvs});
          quo <= {quo[PROB_BITS-2:0], 1'b1};
        end else begin
          rem <= shifted[DEN_BITS-1:0];
          quo <= {quo[PROB_BITS-2:0], 1'b0};
        end
      end
    end
  end

endmodule
